[rtl/boundary_tag_first_fit_allocator_assert.svh]
// Assertion macros for the boundary tag allocator.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define BTFF_ASSERT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define BTFF_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/btff_pkg.sv]
// Package: constants, tag types and sequencer states of the allocator.
`timescale 1ns / 1ps
package btff_pkg;
	localparam int ARENA_BYTES     = 4096;
	localparam int BEGIN_TAG_BYTES = 32;
	localparam int END_TAG_BYTES   = 16;
	localparam int TAG_BYTES       = BEGIN_TAG_BYTES + END_TAG_BYTES;
	localparam int AW              = 12;
	localparam int SW              = 13;

	localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
	localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
	localparam logic [1:0] ST_FREED      = 2'd2;
	localparam logic [1:0] ST_IGNORED    = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;

	typedef struct packed {
		logic [SW-1:0] size;
		logic          free;
		logic          live;
	} hdr_t;

	typedef struct packed {
		logic          v;
		logic [AW-1:0] ptr;
	} link_t;

	typedef struct packed {
		logic [SW-1:0] size;
		logic          free;
	} etag_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_A_RD, S_A_CHK, S_A_SPL1, S_A_SPL2, S_A_TAKE,
		S_F_RD, S_F_CHK, S_F_PV, S_F_PM1, S_F_PM2, S_F_NX, S_F_NX2, S_F_NM,
		S_F_FIN1, S_F_FIN2, S_U1, S_U2, S_DONE
	} state_t;

	// Clamp a written arena size to the legal interval.
	function automatic logic [SW-1:0] sat_arena(input logic [SW-1:0] v);
		logic [SW-1:0] r;
		r = v;
		if (v > SW'(ARENA_BYTES)) r = SW'(ARENA_BYTES);
		if (v < SW'(TAG_BYTES)) r = SW'(TAG_BYTES);
		return r;
	endfunction
endpackage

[rtl/btff_if.sv]
// Channel interfaces: command input, result output, configuration write.
`timescale 1ns / 1ps
interface btff_in_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [btff_pkg::SW-1:0]     request_size;
	logic [btff_pkg::AW-1:0]     payload_offset;
	modport source (output valid, command, request_size, payload_offset, input ready);
	modport sink (input valid, command, request_size, payload_offset, output ready);
endinterface

interface btff_out_if;
	logic                    valid;
	logic                    ready;
	logic [btff_pkg::AW-1:0] result_offset;
	logic [1:0]              status;
	modport source (output valid, result_offset, status, input ready);
	modport sink (input valid, result_offset, status, output ready);
endinterface

interface btff_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [btff_pkg::SW-1:0] arena_size;
	modport source (output valid, arena_size, input ready);
	modport sink (input valid, arena_size, output ready);
endinterface

[rtl/boundary_tag_first_fit_allocator.sv]
// Top level: boundary tag first-fit allocator with its tag memories and sequencer.
`timescale 1ns / 1ps
// Byte arena allocator driven by a small sequencer over four tag memories (begin tag
// header, next link, previous link, end tag), each with one write and one registered
// read port. After reset and after every arena_size write a clearing pass rewrites
// all entries and builds the single free block; items wait, config writes are taken
// at any time and restart the pass. An allocate walks the free list from the head,
// one tag read per node (the walk sets its latency), and splits or unlinks the
// first fitting block, else fails; a free of a live used block merges any free
// neighbours and pushes it at the head, other frees are ignored. One item is in work
// at a time; a finished result waits in the output register while the next is taken.
`include "boundary_tag_first_fit_allocator_assert.svh"
module boundary_tag_first_fit_allocator (
	input  logic         clk,
	input  logic         arst_n,
	btff_in_if.sink      in_ch,
	btff_out_if.source   out_ch,
	btff_cfg_if.sink     cfg
);
	localparam int AW = btff_pkg::AW;
	localparam int SW = btff_pkg::SW;
	localparam int DEPTH = 1 << AW;

	// Tag memories
	btff_pkg::hdr_t  hdr_mem [DEPTH];
	btff_pkg::link_t nxt_mem [DEPTH];
	btff_pkg::link_t prv_mem [DEPTH];
	btff_pkg::etag_t et_mem  [DEPTH];

	btff_pkg::hdr_t  hdr_rd;
	btff_pkg::link_t nxt_rd, prv_rd;
	btff_pkg::etag_t et_rd;

	logic [AW-1:0] bt_raddr, et_raddr;
	logic hdr_we, nxt_we, prv_we, et_we;
	logic [AW-1:0] hdr_wa, nxt_wa, prv_wa, et_wa;
	btff_pkg::hdr_t  hdr_wd;
	btff_pkg::link_t nxt_wd, prv_wd;
	btff_pkg::etag_t et_wd;

	// Sequencer and datapath registers
	btff_pkg::state_t state_q, state_d, u_ret_q;
	logic [AW-1:0] clr_q;
	logic [SW-1:0] arena_q;
	logic          head_v_q;
	logic [AW-1:0] head_q;
	logic          cmd_q;
	logic [SW-1:0] n_q;
	logic [AW-1:0] p_q;
	logic [AW-1:0] cur_q, nb_q, u_node_q;
	logic [SW-1:0] c_size_q, nx_size_q;
	logic          c_live_q, pv_live_q;
	btff_pkg::link_t u_next_q, u_prev_q;
	logic [AW-1:0] res_off_q;
	logic [1:0]    res_st_q;
	logic          out_v_q;
	logic [AW-1:0] out_off_q;
	logic [1:0]    out_st_q;

	// Shared address and size arithmetic
	logic [SW:0]   n_tag, size_rd, nb_wide, pv_lim, pb_wide;
	logic [SW-1:0] rest, cur_end, e1, nb_split, nb_end, merge_pv, merge_nx, init_size;
	logic          take_whole, split_fit, prev_free, prev_fits, nx_in_arena;
	logic          in_acc, out_load;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_load = (state_q == btff_pkg::S_DONE) && (!out_v_q || out_ch.ready);

	always_comb begin
		n_tag      = {1'b0, n_q} + (SW + 1)'(btff_pkg::TAG_BYTES);
		size_rd    = {1'b0, hdr_rd.size};
		take_whole = (hdr_rd.size == n_q) || (size_rd == n_tag);
		split_fit  = n_tag < size_rd;
		rest       = c_size_q - n_q - SW'(btff_pkg::TAG_BYTES);
		cur_end    = SW'(cur_q) + SW'(btff_pkg::BEGIN_TAG_BYTES) + c_size_q;
		e1         = SW'(cur_q) + SW'(btff_pkg::BEGIN_TAG_BYTES) + rest;
		nb_split   = e1 + SW'(btff_pkg::END_TAG_BYTES);
		nb_end     = SW'(nb_q) + SW'(btff_pkg::BEGIN_TAG_BYTES) + n_q;
		prev_free  = (cur_q >= AW'(btff_pkg::END_TAG_BYTES)) && et_rd.free;
		pv_lim     = {1'b0, et_rd.size} + (SW + 1)'(btff_pkg::BEGIN_TAG_BYTES);
		pb_wide    = (SW + 1)'(cur_q) - (SW + 1)'(btff_pkg::END_TAG_BYTES) - pv_lim;
		prev_fits  = ((SW + 1)'(cur_q) - (SW + 1)'(btff_pkg::END_TAG_BYTES)) >= pv_lim;
		merge_pv   = nx_size_q + c_size_q + SW'(btff_pkg::TAG_BYTES);
		merge_nx   = c_size_q + nx_size_q + SW'(btff_pkg::TAG_BYTES);
		nb_wide    = {1'b0, cur_end} + (SW + 1)'(btff_pkg::END_TAG_BYTES);
		nx_in_arena = nb_wide < {1'b0, arena_q};
		init_size  = arena_q - SW'(btff_pkg::TAG_BYTES);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btff_pkg::S_CLR:    if (&clr_q) state_d = btff_pkg::S_IDLE;
			btff_pkg::S_IDLE:   if (in_acc) state_d = (in_ch.command == btff_pkg::CMD_ALLOC) ?
				btff_pkg::S_A_RD : btff_pkg::S_F_RD;
			btff_pkg::S_A_RD:   state_d = (n_q == '0 || !head_v_q) ?
				btff_pkg::S_DONE : btff_pkg::S_A_CHK;
			btff_pkg::S_A_CHK: begin
				priority if (take_whole) state_d = btff_pkg::S_U1;
				else if (split_fit) state_d = btff_pkg::S_A_SPL1;
				else if (!nxt_rd.v) state_d = btff_pkg::S_DONE;
				else state_d = btff_pkg::S_A_CHK;
			end
			btff_pkg::S_A_SPL1: state_d = btff_pkg::S_A_SPL2;
			btff_pkg::S_A_SPL2: state_d = btff_pkg::S_DONE;
			btff_pkg::S_A_TAKE: state_d = btff_pkg::S_DONE;
			btff_pkg::S_F_RD:   state_d = (p_q < AW'(btff_pkg::BEGIN_TAG_BYTES)) ?
				btff_pkg::S_DONE : btff_pkg::S_F_CHK;
			btff_pkg::S_F_CHK: begin
				priority if (!hdr_rd.live || hdr_rd.free) state_d = btff_pkg::S_DONE;
				else if (prev_free && prev_fits) state_d = btff_pkg::S_F_PV;
				else state_d = btff_pkg::S_F_NX;
			end
			btff_pkg::S_F_PV:   state_d = btff_pkg::S_U1;
			btff_pkg::S_F_PM1:  state_d = btff_pkg::S_F_PM2;
			btff_pkg::S_F_PM2:  state_d = btff_pkg::S_F_NX;
			btff_pkg::S_F_NX:   state_d = nx_in_arena ? btff_pkg::S_F_NX2 : btff_pkg::S_F_FIN1;
			btff_pkg::S_F_NX2:  state_d = (hdr_rd.live && hdr_rd.free) ?
				btff_pkg::S_U1 : btff_pkg::S_F_FIN1;
			btff_pkg::S_F_NM:   state_d = btff_pkg::S_F_FIN1;
			btff_pkg::S_F_FIN1: state_d = btff_pkg::S_F_FIN2;
			btff_pkg::S_F_FIN2: state_d = btff_pkg::S_DONE;
			btff_pkg::S_U1:     state_d = btff_pkg::S_U2;
			btff_pkg::S_U2:     state_d = u_ret_q;
			btff_pkg::S_DONE:   if (out_load) state_d = btff_pkg::S_IDLE;
			default:            state_d = btff_pkg::S_CLR;
		endcase
		if (cfg.valid) state_d = btff_pkg::S_CLR;
	end

	// Memory read addresses and write ports
	always_comb begin
		bt_raddr = cur_q;
		et_raddr = p_q - AW'(btff_pkg::TAG_BYTES);
		hdr_we = 1'b0; hdr_wa = cur_q; hdr_wd = '0;
		nxt_we = 1'b0; nxt_wa = cur_q; nxt_wd = '0;
		prv_we = 1'b0; prv_wa = cur_q; prv_wd = '0;
		et_we  = 1'b0; et_wa  = cur_q; et_wd  = '0;
		unique case (state_q)
			btff_pkg::S_CLR: begin
				hdr_we = 1'b1; hdr_wa = clr_q;
				nxt_we = 1'b1; nxt_wa = clr_q;
				prv_we = 1'b1; prv_wa = clr_q;
				et_we  = 1'b1; et_wa  = clr_q;
				if (clr_q == '0) hdr_wd = '{size: init_size, free: 1'b1, live: 1'b1};
				if (SW'(clr_q) == arena_q - SW'(btff_pkg::END_TAG_BYTES))
					et_wd = '{size: init_size, free: 1'b1};
			end
			btff_pkg::S_A_RD: bt_raddr = head_q;
			btff_pkg::S_A_CHK: bt_raddr = nxt_rd.ptr;
			btff_pkg::S_A_SPL1: begin
				hdr_we = 1'b1; hdr_wd = '{size: rest, free: 1'b1, live: c_live_q};
				et_we = 1'b1; et_wa = e1[AW-1:0]; et_wd = '{size: rest, free: 1'b1};
				nxt_we = 1'b1; nxt_wa = nb_split[AW-1:0];
				prv_we = 1'b1; prv_wa = nb_split[AW-1:0];
			end
			btff_pkg::S_A_SPL2: begin
				hdr_we = 1'b1; hdr_wa = nb_q; hdr_wd = '{size: n_q, free: 1'b0, live: 1'b1};
				et_we = 1'b1; et_wa = nb_end[AW-1:0]; et_wd = '{size: n_q, free: 1'b0};
			end
			btff_pkg::S_A_TAKE: begin
				hdr_we = 1'b1; hdr_wd = '{size: c_size_q, free: 1'b0, live: c_live_q};
				et_we = 1'b1; et_wa = cur_end[AW-1:0]; et_wd = '{size: c_size_q, free: 1'b0};
			end
			btff_pkg::S_F_RD: begin
				bt_raddr = p_q - AW'(btff_pkg::BEGIN_TAG_BYTES);
			end
			btff_pkg::S_F_CHK: bt_raddr = pb_wide[AW-1:0];
			btff_pkg::S_F_PV: ;
			btff_pkg::S_F_PM1: begin
				hdr_we = 1'b1; hdr_wd = '{size: c_size_q, free: 1'b0, live: 1'b0};
				et_we = 1'b1; et_wa = cur_end[AW-1:0]; et_wd = '{size: merge_pv, free: 1'b0};
			end
			btff_pkg::S_F_PM2: begin
				hdr_we = 1'b1; hdr_wa = nb_q;
				hdr_wd = '{size: c_size_q, free: 1'b0, live: pv_live_q};
			end
			btff_pkg::S_F_NX: bt_raddr = nb_wide[AW-1:0];
			btff_pkg::S_F_NX2: ;
			btff_pkg::S_F_NM: begin
				hdr_we = 1'b1; hdr_wa = nb_q;
				hdr_wd = '{size: nx_size_q, free: 1'b0, live: 1'b0};
				et_we = 1'b1;
				et_wa = AW'(SW'(nb_q) + SW'(btff_pkg::BEGIN_TAG_BYTES) + nx_size_q);
				et_wd = '{size: merge_nx, free: 1'b1};
			end
			btff_pkg::S_F_FIN1: begin
				hdr_we = 1'b1; hdr_wd = '{size: c_size_q, free: 1'b1, live: c_live_q};
				et_we = 1'b1; et_wa = cur_end[AW-1:0]; et_wd = '{size: c_size_q, free: 1'b1};
				nxt_we = 1'b1; nxt_wd = '{v: head_v_q, ptr: head_v_q ? head_q : '0};
				prv_we = 1'b1;
			end
			btff_pkg::S_F_FIN2: begin
				prv_we = head_v_q; prv_wa = head_q; prv_wd = '{v: 1'b1, ptr: cur_q};
			end
			btff_pkg::S_U1: begin
				nxt_we = u_prev_q.v; nxt_wa = u_prev_q.ptr; nxt_wd = u_next_q;
				prv_we = u_next_q.v; prv_wa = u_next_q.ptr; prv_wd = u_prev_q;
			end
			btff_pkg::S_U2: begin
				nxt_we = 1'b1; nxt_wa = u_node_q;
				prv_we = 1'b1; prv_wa = u_node_q;
			end
			btff_pkg::S_IDLE, btff_pkg::S_DONE: ;
			default: ;
		endcase
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (et_we)  et_mem[et_wa]   <= et_wd;
		hdr_rd <= hdr_mem[bt_raddr];
		nxt_rd <= nxt_mem[bt_raddr];
		prv_rd <= prv_mem[bt_raddr];
		et_rd  <= et_mem[et_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= btff_pkg::S_CLR;
			clr_q    <= '0;
			arena_q  <= SW'(btff_pkg::ARENA_BYTES);
			head_v_q <= 1'b0;
			head_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				arena_q  <= btff_pkg::sat_arena(cfg.arena_size);
				clr_q    <= '0;
				head_v_q <= 1'b0;
			end else if (state_q == btff_pkg::S_CLR) begin
				clr_q <= clr_q + 1'b1;
				if (&clr_q) begin
					head_v_q <= 1'b1;
					head_q   <= '0;
				end
			end
			// Drop the unlinked node from the head
			if (state_q == btff_pkg::S_U1 && head_v_q && head_q == u_node_q) begin
				head_v_q <= u_next_q.v;
				head_q   <= u_next_q.v ? u_next_q.ptr : '0;
			end
			if (state_q == btff_pkg::S_F_FIN2) begin
				head_v_q <= 1'b1;
				head_q   <= cur_q;
			end
			// Hold the result until the sink takes the transaction
			if (out_load) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_off_q <= res_off_q;
			out_st_q  <= res_st_q;
		end
		unique case (state_q)
			btff_pkg::S_IDLE: begin
				cmd_q <= in_ch.command;
				n_q   <= in_ch.request_size;
				p_q   <= in_ch.payload_offset;
				res_off_q <= '0;
			end
			btff_pkg::S_A_RD: begin
				cur_q <= head_q;
				res_st_q <= btff_pkg::ST_ALLOC_FAIL;
			end
			btff_pkg::S_A_CHK: begin
				c_size_q <= hdr_rd.size;
				c_live_q <= hdr_rd.live;
				u_node_q <= cur_q;
				u_next_q <= nxt_rd;
				u_prev_q <= prv_rd;
				u_ret_q  <= btff_pkg::S_A_TAKE;
				if (!take_whole && !split_fit) cur_q <= nxt_rd.ptr;
			end
			btff_pkg::S_A_SPL1: nb_q <= nb_split[AW-1:0];
			btff_pkg::S_A_SPL2: begin
				res_off_q <= nb_q + AW'(btff_pkg::BEGIN_TAG_BYTES);
				res_st_q  <= btff_pkg::ST_ALLOC_OK;
			end
			btff_pkg::S_A_TAKE: begin
				res_off_q <= cur_q + AW'(btff_pkg::BEGIN_TAG_BYTES);
				res_st_q  <= btff_pkg::ST_ALLOC_OK;
			end
			btff_pkg::S_F_RD: begin
				cur_q    <= p_q - AW'(btff_pkg::BEGIN_TAG_BYTES);
				res_st_q <= btff_pkg::ST_IGNORED;
			end
			btff_pkg::S_F_CHK: begin
				c_size_q <= hdr_rd.size;
				c_live_q <= hdr_rd.live;
				nb_q     <= pb_wide[AW-1:0];
			end
			btff_pkg::S_F_PV: begin
				u_node_q  <= nb_q;
				u_next_q  <= nxt_rd;
				u_prev_q  <= prv_rd;
				nx_size_q <= hdr_rd.size;
				pv_live_q <= hdr_rd.live;
				u_ret_q   <= btff_pkg::S_F_PM1;
			end
			btff_pkg::S_F_PM1: c_size_q <= merge_pv;
			btff_pkg::S_F_PM2: begin
				cur_q    <= nb_q;
				c_live_q <= pv_live_q;
			end
			btff_pkg::S_F_NX: nb_q <= nb_wide[AW-1:0];
			btff_pkg::S_F_NX2: begin
				u_node_q  <= nb_q;
				u_next_q  <= nxt_rd;
				u_prev_q  <= prv_rd;
				nx_size_q <= hdr_rd.size;
				u_ret_q   <= btff_pkg::S_F_NM;
			end
			btff_pkg::S_F_NM: c_size_q <= merge_nx;
			btff_pkg::S_F_FIN2: res_st_q <= btff_pkg::ST_FREED;
			default: ;
		endcase
	end

	assign in_ch.ready          = (state_q == btff_pkg::S_IDLE) && !cfg.valid;
	assign cfg.ready            = 1'b1;
	assign out_ch.valid         = out_v_q;
	assign out_ch.result_offset = out_off_q;
	assign out_ch.status        = out_st_q;

	`BTFF_ASSERT_NEXT(a_accept_busy, in_acc, state_q != btff_pkg::S_IDLE, "accepted item left block idle")
	`BTFF_ASSERT_NEXT(a_cfg_clears, cfg.valid, state_q == btff_pkg::S_CLR && clr_q == '0, "config write did not restart clearing")
	`BTFF_ASSERT(a_fail_zero, out_v_q && out_st_q != btff_pkg::ST_ALLOC_OK, out_off_q == '0, "nonzero offset without allocation")
	`BTFF_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.status) && $stable(out_ch.result_offset), "result changed while stalled")
	`BTFF_ASSERT(a_free_mode, state_q == btff_pkg::S_F_FIN1, cmd_q != btff_pkg::CMD_ALLOC, "free merge in allocate")
endmodule

[test/boundary_tag_first_fit_allocator_tb.sv]
// Testbench for the boundary tag first-fit allocator: predicts and checks each result.
`timescale 1ns / 1ps
module boundary_tag_first_fit_allocator_tb;
	localparam int   AW       = btff_pkg::AW;
	localparam int   SW       = btff_pkg::SW;
	localparam int   ARENA    = btff_pkg::ARENA_BYTES;
	localparam int   BTAG     = btff_pkg::BEGIN_TAG_BYTES;
	localparam int   ETAG     = btff_pkg::END_TAG_BYTES;
	localparam int   TAGS     = btff_pkg::TAG_BYTES;
	localparam logic CMD_FREE = ~btff_pkg::CMD_ALLOC;
	localparam int   SPAN     = 2 * ARENA;

	typedef struct {
		logic [AW-1:0] offset;
		logic [1:0]    status;
	} outcome_t;

	// Arena model and queue of pending outcomes
	class arena_scoreboard;
		int  blk_size [SPAN];
		bit  blk_free [SPAN];
		bit  blk_live [SPAN];
		bit  has_nxt [SPAN];
		bit  has_prv [SPAN];
		int  nxt [SPAN];
		int  prv [SPAN];
		int  end_size [SPAN];
		bit  end_free [SPAN];
		bit  head_ok;
		int  head;
		int  arena_len;
		int  errors;
		outcome_t pending[$];

		function void clear_arena(int value);
			int sz;
			sz = value;
			if (sz > ARENA) sz = ARENA;
			if (sz < TAGS) sz = TAGS;
			arena_len = sz;
			for (int i = 0; i < SPAN; i++) begin
				blk_size[i] = 0; blk_free[i] = 0; blk_live[i] = 0;
				has_nxt[i] = 0; has_prv[i] = 0; nxt[i] = 0; prv[i] = 0;
				end_size[i] = 0; end_free[i] = 0;
			end
			blk_size[0] = sz - TAGS;
			blk_free[0] = 1;
			blk_live[0] = 1;
			end_size[sz - ETAG] = sz - TAGS;
			end_free[sz - ETAG] = 1;
			head = 0;
			head_ok = 1;
		endfunction

		function void unlink(int c);
			if (head_ok && head == c) begin
				head_ok = has_nxt[c];
				head = has_nxt[c] ? nxt[c] : 0;
			end
			if (has_prv[c]) begin
				has_nxt[prv[c]] = has_nxt[c];
				nxt[prv[c]] = nxt[c];
			end
			if (has_nxt[c]) begin
				has_prv[nxt[c]] = has_prv[c];
				prv[nxt[c]] = prv[c];
			end
			has_nxt[c] = 0; has_prv[c] = 0; nxt[c] = 0; prv[c] = 0;
		endfunction

		function void push_head(int c);
			has_prv[c] = 0;
			prv[c] = 0;
			has_nxt[c] = head_ok;
			nxt[c] = head_ok ? head : 0;
			if (head_ok) begin
				has_prv[head] = 1;
				prv[head] = c;
			end
			head = c;
			head_ok = 1;
		endfunction

		// Walk the free list first-fit; take whole or carve from the tail
		function logic [1:0] allocate(int n, output int off);
			int  cur;
			bit  ok;
			int  rest;
			int  e1;
			int  nb;
			cur = head;
			ok = head_ok;
			off = 0;
			if (n == 0) return btff_pkg::ST_ALLOC_FAIL;
			for (int steps = 0; ok && steps < ARENA; steps++) begin
				if (blk_size[cur] == n || blk_size[cur] == n + TAGS) begin
					unlink(cur);
					blk_free[cur] = 0;
					end_free[cur + BTAG + blk_size[cur]] = 0;
					off = cur + BTAG;
					return btff_pkg::ST_ALLOC_OK;
				end
				if (n + TAGS < blk_size[cur]) begin
					rest = blk_size[cur] - n - TAGS;
					e1 = cur + BTAG + rest;
					nb = e1 + ETAG;
					blk_size[cur] = rest;
					end_size[e1] = rest;
					end_free[e1] = 1;
					blk_size[nb] = n; blk_free[nb] = 0; blk_live[nb] = 1;
					has_nxt[nb] = 0; has_prv[nb] = 0; nxt[nb] = 0; prv[nb] = 0;
					end_size[nb + BTAG + n] = n;
					end_free[nb + BTAG + n] = 0;
					off = nb + BTAG;
					return btff_pkg::ST_ALLOC_OK;
				end
				ok = has_nxt[cur];
				cur = nxt[cur];
			end
			return btff_pkg::ST_ALLOC_FAIL;
		endfunction

		// Merge with free neighbors and push at the head
		function logic [1:0] release_block(int p);
			int cur;
			int psz;
			int pb;
			int nb;
			int e;
			if (p < BTAG) return btff_pkg::ST_IGNORED;
			cur = p - BTAG;
			if (!blk_live[cur] || blk_free[cur]) return btff_pkg::ST_IGNORED;
			if (cur >= ETAG && end_free[cur - ETAG]) begin
				psz = end_size[cur - ETAG];
				pb = cur - ETAG;
				if (pb >= psz + BTAG) begin
					pb -= psz + BTAG;
					unlink(pb);
					blk_free[pb] = 0;
					blk_size[pb] += blk_size[cur] + TAGS;
					end_size[cur + BTAG + blk_size[cur]] = blk_size[pb];
					blk_live[cur] = 0;
					cur = pb;
				end
			end
			nb = cur + BTAG + blk_size[cur] + ETAG;
			if (nb < arena_len && blk_live[nb] && blk_free[nb]) begin
				unlink(nb);
				blk_size[cur] += blk_size[nb] + TAGS;
				end_size[nb + BTAG + blk_size[nb]] = blk_size[cur];
				blk_live[nb] = 0;
				blk_free[nb] = 0;
			end
			blk_free[cur] = 1;
			e = cur + BTAG + blk_size[cur];
			end_free[e] = 1;
			end_size[e] = blk_size[cur];
			push_head(cur);
			return btff_pkg::ST_FREED;
		endfunction

		// Note one accepted command and queue its outcome
		function outcome_t note_command(logic cmd, logic [SW-1:0] req, logic [AW-1:0] poff);
			outcome_t o;
			int off;
			off = 0;
			if (cmd == btff_pkg::CMD_ALLOC) o.status = allocate(int'(req), off);
			else o.status = release_block(int'(poff));
			o.offset = (o.status == btff_pkg::ST_ALLOC_OK) ? AW'(off) : '0;
			pending.push_back(o);
			return o;
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [AW-1:0] offset, logic [1:0] status);
			outcome_t o;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result offset=%0d status=%0d", offset, status));
			end else begin
				o = pending.pop_front();
				if (status !== o.status)
					report($sformatf("status %0d, expected %0d", status, o.status));
				if (offset !== o.offset)
					report($sformatf("offset %0d, expected %0d", offset, o.offset));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	btff_in_if  in_ch ();
	btff_out_if out_ch ();
	btff_cfg_if cfg ();

	boundary_tag_first_fit_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg    (cfg.sink)
	);

	arena_scoreboard sb = new();
	int  held[$];
	int  freed_once[$];
	int  burst_left;
	int  gap_len;
	bit  hold_req;
	int  hold_cnt;
	int  stall_mode;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Receiver: random stall pattern, plus long hold-offs while requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cnt <= 0;
			stall_mode <= 0;
		end else begin
			if (hold_req && hold_cnt == 0) hold_cnt <= 400;
			else if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
			else if (hold_cnt == 1) hold_cnt <= 0;
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
			if (hold_cnt > 1 || (hold_req && hold_cnt == 0)) out_ch.ready <= 1'b0;
			else if (stall_mode == 0) out_ch.ready <= 1'b1;
			else if (stall_mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
			else out_ch.ready <= ($urandom_range(0, 3) == 0);
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.result_offset, out_ch.status);
	end

	// Offer one command; hold valid across bursts, drop it for gaps
	task send_command(logic cmd, logic [SW-1:0] req, logic [AW-1:0] poff);
		outcome_t o;
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.request_size <= req;
		in_ch.payload_offset <= poff;
		do @(posedge clk); while (!in_ch.ready);
		o = sb.note_command(cmd, req, poff);
		if (cmd == btff_pkg::CMD_ALLOC && o.status == btff_pkg::ST_ALLOC_OK)
			held.push_back(int'(o.offset));
		if (cmd == CMD_FREE && o.status == btff_pkg::ST_FREED) freed_once.push_back(int'(poff));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_len > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
	endtask

	task alloc_cmd(int n);
		send_command(btff_pkg::CMD_ALLOC, SW'(n), AW'($urandom));
	endtask

	task free_cmd(int p);
		send_command(CMD_FREE, SW'($urandom), AW'(p));
	endtask

	task drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Rewrite arena_size once idle
	task write_arena(int value);
		drain();
		cfg.valid <= 1'b1;
		cfg.arena_size <= SW'(value);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.clear_arena(value & 13'h1FFF);
		held.delete();
		freed_once.delete();
	endtask

	// Random mix: mostly legal alloc/free pairs, some noise and stale frees
	task random_phase(int count);
		int pick;
		int k;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (held.size() > 0 && pick < 45) begin
				k = $urandom_range(0, held.size() - 1);
				free_cmd(held[k]);
				held.delete(k);
			end else if (pick < 50) begin
				free_cmd($urandom_range(0, 4095));
			end else if (pick < 54 && freed_once.size() > 0) begin
				free_cmd(freed_once[$urandom_range(0, freed_once.size() - 1)]);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60) alloc_cmd($urandom_range(1, 64));
				else if (pick < 85) alloc_cmd($urandom_range(65, 400));
				else if (pick < 95) alloc_cmd($urandom_range(0, 8191));
				else alloc_cmd(0);
			end
		end
	endtask

	initial begin
		int a;
		int b;
		int c;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = btff_pkg::CMD_ALLOC;
		in_ch.request_size = '0;
		in_ch.payload_offset = '0;
		cfg.valid = 1'b0;
		cfg.arena_size = '0;
		hold_req = 1'b0;
		burst_left = 0;
		sb.errors = 0;
		sb.clear_arena(ARENA);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, exact fits, bad frees, merges, double free
		alloc_cmd(0);
		alloc_cmd(8191);
		alloc_cmd(4096);
		alloc_cmd(ARENA - TAGS);
		free_cmd(BTAG);
		alloc_cmd(ARENA - 2 * TAGS);
		free_cmd(BTAG);
		free_cmd(0);
		free_cmd(BTAG - 1);
		free_cmd(4095);
		alloc_cmd(100);
		a = held.size() ? held[$] : 0;
		alloc_cmd(200);
		b = held.size() ? held[$] : 0;
		alloc_cmd(300);
		c = held.size() ? held[$] : 0;
		held.delete();
		free_cmd(b);
		free_cmd(b);
		free_cmd(a);
		free_cmd(c);
		alloc_cmd(1);
		alloc_cmd(4095);

		random_phase(200);

		// Long receiver hold-off while the sender keeps offering
		hold_req = 1'b1;
		random_phase(30);
		hold_req = 1'b0;
		random_phase(80);

		write_arena(64);
		alloc_cmd(16);
		alloc_cmd(1);
		random_phase(40);
		write_arena(0);
		alloc_cmd(1);
		random_phase(20);
		write_arena(8191);
		random_phase(120);
		write_arena(1000);
		random_phase(120);
		write_arena(4096);
		random_phase(80);

		drain();
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Timeout
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/btff_pkg.sv
rtl/btff_if.sv
rtl/boundary_tag_first_fit_allocator.sv
test/boundary_tag_first_fit_allocator_tb.sv
